// ----- rtl/core/tsfs_pkg.sv -----
// ---------------------------------------------------------------------------
// tsfs_pkg: shared types and constants for the torque sensor filter/scale
// Sequencer states, register indexes and the divider request/response words.
// ---------------------------------------------------------------------------
package tsfs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    // configuration register indexes
    localparam logic [2:0] REG_BW_RISE        = 3'd0;
    localparam logic [2:0] REG_BW_FALL        = 3'd1;
    localparam logic [2:0] REG_SENSOR_OFFSET  = 3'd2;
    localparam logic [2:0] REG_SENSOR_SLOPE   = 3'd3;
    localparam logic [2:0] REG_SENSOR_DIVISOR = 3'd4;
    localparam logic [2:0] REG_MOTOR_OFFSET   = 3'd5;
    localparam logic [2:0] REG_MOTOR_SLOPE    = 3'd6;
    localparam logic [2:0] REG_MOTOR_DIVISOR  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FMUL,
        ST_FDIV_GO,
        ST_FDIV,
        ST_SBASE,
        ST_SMUL,
        ST_SDIV_GO,
        ST_SDIV,
        ST_MBASE,
        ST_MMUL,
        ST_MABS,
        ST_MDIV_GO,
        ST_MDIV,
        ST_OUT
    } state_t;

    // num_hi must be below den, so the quotient fits in 16 bits
    typedef struct packed {
        logic        start;
        logic [15:0] num_hi;
        logic [15:0] num_lo;
        logic [15:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/torque_sensor_filter_scale.sv -----
// ---------------------------------------------------------------------------
// torque_sensor_filter_scale: torque sensor low-pass filter and scaling
// Asymmetric IIR filter, offset/slope/divisor scaling and motor torque.
// ---------------------------------------------------------------------------
// Sequence: from the accepting edge to m_tvalid the block runs three divider
//   passes of 16 steps, each ending in a done strobe, plus ten sequencer steps.
// Invalid samples, saturated quotients or a zero motor product skip a pass.
// s_tready is high only in idle, so a new word waits until the last is done,
//   and a result still held in the output register delays the next word.
// Reset: async, active low; filter, torque and config to defaults, output empty.
module torque_sensor_filter_scale
    import tsfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] adc_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [15:0] filtered_adc, [31:16] torque_value,
                                   // [47:32] motor_torque
);

    state_t state_reg, state_next;

    logic [15:0]        bw_rise_reg, bw_fall_reg, sensor_offset_reg, motor_offset_reg;
    logic [14:0]        sensor_slope_reg, sensor_divisor_reg, motor_divisor_reg;
    logic signed [15:0] motor_slope_reg;

    logic [15:0]        filter_reg, torque_reg;
    logic [15:0]        sample_reg, bw_reg, base_reg, mt_reg;
    logic signed [33:0] prod_reg;
    logic [30:0]        mag_reg;
    logic               neg_reg;

    logic               m_valid_reg;
    logic [47:0]        m_data_reg;

    logic [15:0]        bw_sel, bw_eff;
    logic               sample_bad;
    logic [31:0]        acc;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    logic signed [33:0] prod_neg;
    logic               out_free;
    logic [15:0]        q;
    logic               sens_sat, mot_sat, mag_zero;

    div_req_t div_req;
    div_rsp_t div_rsp;

    tsfs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign q          = div_rsp.quotient;
    assign sample_bad = (sample_reg == SAMPLE_MASK);
    assign bw_sel     = (sample_reg > filter_reg) ? bw_rise_reg : bw_fall_reg;
    assign bw_eff     = (bw_sel == 16'd0) ? 16'd1 : bw_sel;
    assign acc        = prod_reg[31:0] + {16'd0, sample_reg};
    assign prod_neg   = -prod_reg;
    assign sens_sat   = (prod_reg[30:16] >= sensor_divisor_reg);
    assign mot_sat    = (mag_reg[30:16] >= motor_divisor_reg);
    assign mag_zero   = (mag_reg == 31'd0);
    assign out_free   = !m_valid_reg || m_tready;

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = 17'sd0;
        mul_b = 17'sd0;
        case (state_reg)
            ST_FMUL:
            begin
                mul_a = $signed({1'b0, 16'(bw_eff - 16'd1)});
                mul_b = $signed({1'b0, filter_reg});
            end
            ST_SMUL:
            begin
                mul_a = $signed({2'b00, sensor_slope_reg});
                mul_b = $signed({1'b0, base_reg});
            end
            ST_MMUL:
            begin
                mul_a = {motor_slope_reg[15], motor_slope_reg};
                mul_b = $signed({1'b0, base_reg});
            end
            default:
            begin
                mul_a = 17'sd0;
                mul_b = 17'sd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_FMUL;
            ST_FMUL:    state_next = ST_FDIV_GO;
            ST_FDIV_GO: state_next = sample_bad ? ST_SBASE : ST_FDIV;
            ST_FDIV:    if (div_rsp.done) state_next = ST_SBASE;
            ST_SBASE:   state_next = ST_SMUL;
            ST_SMUL:    state_next = ST_SDIV_GO;
            ST_SDIV_GO: state_next = sens_sat ? ST_MBASE : ST_SDIV;
            ST_SDIV:    if (div_rsp.done) state_next = ST_MBASE;
            ST_MBASE:   state_next = ST_MMUL;
            ST_MMUL:    state_next = ST_MABS;
            ST_MABS:    state_next = ST_MDIV_GO;
            ST_MDIV_GO: state_next = (mag_zero || mot_sat) ? ST_OUT : ST_MDIV;
            ST_MDIV:    if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready       = 1'b0;
        div_req.start  = 1'b0;
        div_req.num_hi = acc[31:16];
        div_req.num_lo = acc[15:0];
        div_req.den    = bw_reg;
        case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_FDIV_GO: div_req.start = !sample_bad;
            ST_SDIV_GO:
            begin
                div_req.start  = !sens_sat;
                div_req.num_hi = prod_reg[31:16];
                div_req.num_lo = prod_reg[15:0];
                div_req.den    = {1'b0, sensor_divisor_reg};
            end
            ST_MDIV_GO:
            begin
                div_req.start  = !(mag_zero || mot_sat);
                div_req.num_hi = {1'b0, mag_reg[30:16]};
                div_req.num_lo = mag_reg[15:0];
                div_req.den    = {1'b0, motor_divisor_reg};
            end
            default:    s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            m_valid_reg        <= 1'b0;
            filter_reg         <= '0;
            torque_reg         <= '0;
            bw_rise_reg        <= 16'd16;
            bw_fall_reg        <= 16'd16;
            sensor_offset_reg  <= '0;
            sensor_slope_reg   <= 15'd1;
            sensor_divisor_reg <= 15'd1;
            motor_offset_reg   <= '0;
            motor_slope_reg    <= 16'sd1;
            motor_divisor_reg  <= 15'd1;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BW_RISE:        bw_rise_reg        <= cfg_wdata;
                    REG_BW_FALL:        bw_fall_reg        <= cfg_wdata;
                    REG_SENSOR_OFFSET:  sensor_offset_reg  <= cfg_wdata;
                    REG_SENSOR_SLOPE:   sensor_slope_reg   <= cfg_wdata[14:0];
                    REG_SENSOR_DIVISOR: sensor_divisor_reg <= cfg_wdata[14:0];
                    REG_MOTOR_OFFSET:   motor_offset_reg   <= cfg_wdata;
                    REG_MOTOR_SLOPE:    motor_slope_reg    <= $signed(cfg_wdata);
                    REG_MOTOR_DIVISOR:  motor_divisor_reg  <= cfg_wdata[14:0];
                    default:            ;
                endcase
            end

            if (state_reg == ST_FDIV && div_rsp.done)
                filter_reg <= q;

            if (state_reg == ST_SDIV_GO && sens_sat)
                torque_reg <= 16'hFFFF;
            else if (state_reg == ST_SDIV && div_rsp.done)
                torque_reg <= q;

            if (state_reg == ST_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // datapath words
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sample_reg <= s_tdata & SAMPLE_MASK;

        case (state_reg)
            ST_FMUL:
            begin
                prod_reg <= mul_p;
                bw_reg   <= bw_eff;
            end
            ST_SMUL, ST_MMUL: prod_reg <= mul_p;
            ST_SBASE:
                base_reg <= (filter_reg > sensor_offset_reg) ?
                            16'(filter_reg - sensor_offset_reg) : 16'd0;
            ST_MBASE:
                base_reg <= (torque_reg > motor_offset_reg) ?
                            16'(torque_reg - motor_offset_reg) : 16'd0;
            ST_MABS:
            begin
                neg_reg <= prod_reg[33];
                mag_reg <= prod_reg[33] ? prod_neg[30:0] : prod_reg[30:0];
            end
            ST_MDIV_GO:
            begin
                // zero divisor lands here too, saturating by sign
                if (mag_zero)
                    mt_reg <= 16'd0;
                else if (mot_sat)
                    mt_reg <= neg_reg ? 16'h8000 : 16'h7FFF;
            end
            ST_MDIV:
            begin
                if (div_rsp.done)
                begin
                    if (!neg_reg)
                        mt_reg <= (q > 16'd32767) ? 16'h7FFF : q;
                    else
                        mt_reg <= (q > 16'd32768) ? 16'h8000 : 16'(~q + 16'd1);
                end
            end
            ST_OUT:
                if (out_free)
                    m_data_reg <= {mt_reg, torque_reg, filter_reg};
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/core/tsfs_div.sv -----
// ---------------------------------------------------------------------------
// tsfs_div: iterative restoring divider
// 32-by-16 division yielding a 16-bit quotient, one bit per cycle while busy.
// ---------------------------------------------------------------------------
module tsfs_div
    import tsfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] den_reg, den_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic        ge;

    assign trial = {rem_reg, quo_reg[15]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.num_hi;
            quo_next  = req.num_lo;
            den_next  = req.den;
            cnt_next  = 4'd15;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out the top as quotient bits shift in
            rem_next = ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            quo_next = {quo_reg[14:0], ge};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- test/tb_torque_sensor_filter_scale.sv -----
// ---------------------------------------------------------------------------
// tb_torque_sensor_filter_scale: self-checking bench for the torque filter
// Feeds ADC sample words through the stream input and predicts every result
// word with a local model of the filter and both scaling stages. Results are
// checked in order, field by field. Register settings change between phases,
// with random idling on both sides and two long output hold-offs per run.
// ---------------------------------------------------------------------------
module tb_torque_sensor_filter_scale
    import tsfs_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LATENCY     = 61;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 121;
    localparam int LONG_STALL  = 400;

    // same layout as m_tdata: filtered_adc in the lowest bits
    typedef struct packed {
        logic signed [15:0] motor_torque;
        logic [15:0]        torque_value;
        logic [15:0]        filtered_adc;
    } torque_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = REG_BW_RISE;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // local copy of the registers and filter state
    logic [15:0]        bw_rise;
    logic [15:0]        bw_fall;
    logic [15:0]        sensor_offset;
    logic [14:0]        sensor_slope;
    logic [14:0]        sensor_divisor;
    logic [15:0]        motor_offset;
    logic signed [15:0] motor_slope;
    logic [14:0]        motor_divisor;
    logic [15:0]        filt_state;
    logic [15:0]        held_torque;

    logic [15:0]  pending_samples[$];
    torque_word_t expected_words[$];
    logic [15:0]  next_regs [8];

    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int stall_req_seq   = 0;
    int stall_ack_seq   = 0;
    int stall_left      = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    bit in_fire         = 1'b0;

    torque_sensor_filter_scale dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void load_defaults();
        bw_rise        = 16'd16;
        bw_fall        = 16'd16;
        sensor_offset  = '0;
        sensor_slope   = 15'd1;
        sensor_divisor = 15'd1;
        motor_offset   = '0;
        motor_slope    = 16'sd1;
        motor_divisor  = 15'd1;
        filt_state     = '0;
        held_torque    = '0;
    endfunction

    function automatic void set_register(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            REG_BW_RISE:        bw_rise        = data;
            REG_BW_FALL:        bw_fall        = data;
            REG_SENSOR_OFFSET:  sensor_offset  = data;
            REG_SENSOR_SLOPE:   sensor_slope   = data[14:0];
            REG_SENSOR_DIVISOR: sensor_divisor = data[14:0];
            REG_MOTOR_OFFSET:   motor_offset   = data;
            REG_MOTOR_SLOPE:    motor_slope    = data;
            REG_MOTOR_DIVISOR:  motor_divisor  = data[14:0];
            default: ;
        endcase
    endfunction

    // one sample in, one result word out; updates the filter state
    function automatic torque_word_t filter_and_scale(input logic [15:0] raw);
        logic [15:0]  smp;
        logic [31:0]  bw;
        logic [31:0]  acc;
        logic [31:0]  base;
        logic [31:0]  scaled;
        longint       prod;
        longint       mt;
        torque_word_t w;
        smp = raw & SAMPLE_MASK;
        bw = (smp > filt_state) ? 32'(bw_rise) : 32'(bw_fall);
        if (bw == 32'd0)
            bw = 32'd1;
        if (smp != SAMPLE_MASK)
        begin
            acc = (bw - 32'd1) * 32'(filt_state) + 32'(smp);
            filt_state = 16'(acc / bw);
        end
        base = (filt_state > sensor_offset) ? 32'(filt_state - sensor_offset) : 32'd0;
        scaled = 32'(sensor_slope) * base;
        if (sensor_divisor == '0)
            scaled = '1;
        else
            scaled = scaled / 32'(sensor_divisor);
        held_torque = (scaled > 32'h0000_FFFF) ? 16'hFFFF : scaled[15:0];
        base = (held_torque > motor_offset) ? 32'(held_torque - motor_offset) : 32'd0;
        prod = longint'(motor_slope) * longint'(base);
        // zero divisor saturates by the sign of the product
        if (motor_divisor == '0)
            mt = (prod > 0) ? 32767 : ((prod < 0) ? -32768 : 0);
        else
            mt = prod / longint'(motor_divisor);
        if (mt > 32767)
            mt = 32767;
        else if (mt < -32768)
            mt = -32768;
        w.filtered_adc = filt_state;
        w.torque_value = held_torque;
        w.motor_torque = 16'(mt);
        return w;
    endfunction

    // sender: holds a word until taken, then maybe idles
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_samples.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls plus the occasional long hold-off
    always @(negedge clk)
    begin
        if (stall_req_seq != stall_ack_seq)
        begin
            stall_ack_seq <= stall_req_seq;
            stall_left    <= LONG_STALL;
            m_tready      <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        torque_word_t got;
        torque_word_t want;
        if (!rst_n)
        begin
            load_defaults();
            in_fire <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                set_register(cfg_addr, cfg_wdata);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_words.size() == 0)
                begin
                    $error("result word %h with nothing expected", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.filtered_adc !== want.filtered_adc)
                    begin
                        $error("filtered_adc: expected %0d, got %0d",
                               want.filtered_adc, got.filtered_adc);
                        error_count++;
                    end
                    if (got.torque_value !== want.torque_value)
                    begin
                        $error("torque_value: expected %0d, got %0d",
                               want.torque_value, got.torque_value);
                        error_count++;
                    end
                    if (got.motor_torque !== want.motor_torque)
                    begin
                        $error("motor_torque: expected %0d, got %0d",
                               $signed(want.motor_torque), $signed(got.motor_torque));
                        error_count++;
                    end
                end
            end
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_words.push_back(filter_and_scale(s_tdata));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("torque_sensor_filter_scale verification failed");
            $finish;
        end
    end

    task automatic offer(input logic [15:0] smp);
        pending_samples.push_back(smp);
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_regs();
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), next_regs[i]);
    endtask

    // zero and all-ones turn up often; all-ones masks to the top of 15-bit fields
    function automatic logic [15:0] biased(input int typical_max);
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, typical_max));
        endcase
    endfunction

    task automatic pick_random_regs();
        logic [15:0] ms;
        ms = biased(40);
        if ($urandom_range(0, 1) == 1)
            ms = -ms;
        next_regs[REG_BW_RISE]        = biased(64);
        next_regs[REG_BW_FALL]        = biased(64);
        next_regs[REG_SENSOR_OFFSET]  = biased(4000);
        next_regs[REG_SENSOR_SLOPE]   = biased(16);
        next_regs[REG_SENSOR_DIVISOR] = biased(16);
        next_regs[REG_MOTOR_OFFSET]   = biased(4000);
        next_regs[REG_MOTOR_SLOPE]    = ms;
        next_regs[REG_MOTOR_DIVISOR]  = biased(64);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 19))
            0, 1:    return SAMPLE_MASK;
            2:       return 16'h0000;
            3:       return SAMPLE_MASK - 16'd1;
            4, 5, 6: return filt_state + 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom());
        endcase
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        sender_idle_pct = 9;
        recv_idle_pct   = 76;

        // defaults: invalid words from reset and after a rise, bit patterns
        offer(16'h0000); offer(16'hFFFF); offer(16'hFFFE); offer(16'hFFFF);
        offer(16'h8000); offer(16'h0001); offer(16'h7FFF); offer(16'hAAAA);
        offer(16'h5555); offer(16'h0000);
        wait_idle();

        // instant rise, slowest fall, full sensor slope, most negative motor slope
        next_regs[REG_BW_RISE]        = 16'd1;
        next_regs[REG_BW_FALL]        = 16'hFFFF;
        next_regs[REG_SENSOR_OFFSET]  = 16'd0;
        next_regs[REG_SENSOR_SLOPE]   = 16'h7FFF;
        next_regs[REG_SENSOR_DIVISOR] = 16'd1;
        next_regs[REG_MOTOR_OFFSET]   = 16'd0;
        next_regs[REG_MOTOR_SLOPE]    = 16'h8000;
        next_regs[REG_MOTOR_DIVISOR]  = 16'd1;
        load_regs();
        offer(16'hFFFE); offer(16'h0000); offer(16'hFFFF); offer(16'h0001); offer(16'h1234);
        wait_idle();

        // slowest rise, instant fall, offsets at the top
        next_regs[REG_BW_RISE]        = 16'hFFFF;
        next_regs[REG_BW_FALL]        = 16'd1;
        next_regs[REG_SENSOR_OFFSET]  = 16'hFFFF;
        next_regs[REG_SENSOR_DIVISOR] = 16'h7FFF;
        next_regs[REG_MOTOR_OFFSET]   = 16'hFFFF;
        next_regs[REG_MOTOR_SLOPE]    = 16'h7FFF;
        next_regs[REG_MOTOR_DIVISOR]  = 16'h7FFF;
        load_regs();
        offer(16'h0000); offer(16'hFFFE); offer(16'h8000); offer(16'hFFFF);
        wait_idle();

        // zero bandwidths and zero divisors
        next_regs[REG_BW_RISE]        = 16'd0;
        next_regs[REG_BW_FALL]        = 16'd0;
        next_regs[REG_SENSOR_OFFSET]  = 16'd0;
        next_regs[REG_SENSOR_SLOPE]   = 16'd3;
        next_regs[REG_SENSOR_DIVISOR] = 16'd0;
        next_regs[REG_MOTOR_OFFSET]   = 16'd0;
        next_regs[REG_MOTOR_SLOPE]    = 16'hFFFB;
        next_regs[REG_MOTOR_DIVISOR]  = 16'd0;
        load_regs();
        offer(16'h1000); offer(16'hFFFF); offer(16'h0000);
        wait_idle();
        write_reg(REG_MOTOR_SLOPE, 16'd7);
        offer(16'h2000);
        wait_idle();
        write_reg(REG_MOTOR_OFFSET, 16'hFFFF);
        offer(16'h3000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES / 3)
            begin
                sender_idle_pct = 76;
                recv_idle_pct   = 9;
            end
            else if (ph == 2 * PHASES / 3)
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            wait_idle();
            pick_random_regs();
            load_regs();
            for (int n = 0; n < PHASE_WORDS; n++)
                offer(rand_sample());
            // long output hold-off while the sender keeps offering
            if (ph == 1 || ph == 9)
                stall_req_seq++;
        end

        wait_idle();
        repeat (LATENCY + 8) @(posedge clk);
        if (error_count == 0)
            $display("torque_sensor_filter_scale verification clean");
        else
            $display("torque_sensor_filter_scale verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/tsfs_pkg.sv
rtl/core/tsfs_div.sv
rtl/core/torque_sensor_filter_scale.sv
test/tb_torque_sensor_filter_scale.sv
